// ===== hw/rtl/median_filter_3x3_stream_defines.svh =====
// Assertion macros used by the checker file of the median filter.
`ifndef MEDIAN_FILTER_3X3_STREAM_DEFINES_SVH
`define MEDIAN_FILTER_3X3_STREAM_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define MF3_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("median filter check failed");

// Next-cycle implication, disabled while reset is high.
`define MF3_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("median filter check failed");

// Condition that must hold in the cycle after reset is seen.
`define MF3_ASSERT_POST_RST(lbl, clk, rst, cons) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("median filter check failed after reset");

`endif

// ===== hw/rtl/mf3_pkg.sv =====
`timescale 1ns / 1ps

package mf3_pkg;

   // Frame geometry
   localparam int MAX_WIDTH     = 2048;
   localparam int COL_W         = $clog2(MAX_WIDTH);
   localparam int FRAME_WIDTH_W = 12;
   localparam int FRAME_HEIGHT_W = 16;
   localparam int ROW_W         = 16;
   localparam int OUT_COL_W     = 11;
   localparam int PIX_W         = 8;
   // compare width for column arithmetic (column + 1 against width)
   localparam int CMP_W = (COL_W + 1 > FRAME_WIDTH_W) ? COL_W + 1 : FRAME_WIDTH_W;

   localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = FRAME_WIDTH_W'(640);
   localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = FRAME_HEIGHT_W'(480);

   // Configuration register indexes
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   // Window and result queue
   localparam int WIN_N       = 9;
   localparam int MAX_RESULTS = 3;
   localparam int PUSH_CNT_W  = $clog2(MAX_RESULTS + 1);
   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Stream widths
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_FIELDS_W = PIX_W + ROW_W + OUT_COL_W;
   localparam int RSP_TDATA_W = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef logic [PIX_W-1:0] pixel_type;
   typedef pixel_type [WIN_N-1:0] window_type;

   typedef struct packed {
      logic                 last_frame;
      logic                 last_item;
      logic [OUT_COL_W-1:0] col;
      logic [ROW_W-1:0]     row;
      pixel_type            pixel;
   } rsp_item_type;

   typedef rsp_item_type [MAX_RESULTS-1:0] rsp_group_type;

   // Position flags worked out when a pixel is taken in
   typedef struct packed {
      logic row_ge1;
      logic col_ge1;
      logic interior;
      logic last_col;
      logic last_row;
   } pos_flags_type;

   function automatic pixel_type min2(input pixel_type a, input pixel_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic pixel_type max2(input pixel_type a, input pixel_type b);
      return (a < b) ? b : a;
   endfunction

   function automatic pixel_type min3(input pixel_type a, input pixel_type b,
                                      input pixel_type c);
      return min2(min2(a, b), c);
   endfunction

   function automatic pixel_type max3(input pixel_type a, input pixel_type b,
                                      input pixel_type c);
      return max2(max2(a, b), c);
   endfunction

   function automatic pixel_type med3(input pixel_type a, input pixel_type b,
                                      input pixel_type c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

endpackage

// ===== hw/rtl/median_filter_3x3_stream.sv =====
`timescale 1ns / 1ps

// 3x3 median filter on a raster-order stream of 8-bit pixels.
// req_* carries one pixel per transfer, row by row, frame after frame.
// rsp_* carries filtered pixels tagged with row and column; interior pixels
// get the median of their neighborhood, border pixels are copied as they are.
// A pixel is emitted once its neighborhood is in, so the output trails the
// input by one row and one column; pixels of the last row come out with
// their own input. One input causes zero to three results.
// csr_* sets frame_width (index 0) and frame_height (index 1); write them
// only while no frame is in flight.
// Throughput: one pixel per cycle while the result queue has room;
// req_tready drops unless the eight-entry queue can take the results of the
// pixel in the input register and of a new one. Results caused by a transfer
// pass the input register (with the line store read) and then the queue
// write before they are valid.
// Reset clears the position counters, the column window and the queue and
// loads 640 x 480; line stores are not cleared. When the receiver stalls,
// results collect in the queue and req_tready drops before it can overflow.
module median_filter_3x3_stream (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata: [7:0] pixel_in
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [mf3_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // rsp_tdata: [7:0] pixel_out, [23:8] out_row, [34:24] out_col, rest zero
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [mf3_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // rsp_tuser: [0] last_of_item
   output logic                                 rsp_tuser,
   output logic                                 rsp_tlast,
   input  logic                                 csr_we,
   input  logic [mf3_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [mf3_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import mf3_pkg::*;

   // configuration
   logic [FRAME_WIDTH_W-1:0]  frame_width_ff;
   logic [FRAME_HEIGHT_W-1:0] frame_height_ff;
   logic [CMP_W-1:0]          width_eff;
   logic [ROW_W:0]            height_eff;

   // position counters
   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;
   logic [CMP_W-1:0] col_plus1;
   logic [ROW_W:0]   row_plus1;
   pos_flags_type    pos;
   logic             accept;

   // stage 1
   logic             s1_valid_ff;
   pixel_type        s1_pixel_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [ROW_W-1:0] s1_row_ff;
   pos_flags_type    s1_pos_ff;
   logic             byp_ff;
   logic [2*PIX_W-1:0] byp_data_ff;
   logic [2*PIX_W-1:0] line_rd;
   logic [2*PIX_W-1:0] line_now;
   pixel_type        up2;
   pixel_type        up1;
   pixel_type        win_ff [6];
   window_type       nbhd;
   pixel_type        median;

   // results
   rsp_item_type     res [MAX_RESULTS];
   logic             res_v [MAX_RESULTS];
   rsp_group_type    push_items;
   logic [PUSH_CNT_W-1:0] push_cnt;
   logic [QCNT_W-1:0] q_count;
   logic [QCNT_W:0]   q_need;
   rsp_item_type     q_item;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[FRAME_WIDTH_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[FRAME_HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // effective frame size: zero acts as one, width capped at the line store
   always_comb begin
      if (frame_width_ff == '0) begin
         width_eff = CMP_W'(1);
      end else if (CMP_W'(frame_width_ff) > CMP_W'(MAX_WIDTH)) begin
         width_eff = CMP_W'(MAX_WIDTH);
      end else begin
         width_eff = CMP_W'(frame_width_ff);
      end
      if (frame_height_ff == '0) begin
         height_eff = (ROW_W + 1)'(1);
      end else begin
         height_eff = (ROW_W + 1)'(frame_height_ff);
      end
   end

   // position flags of the pixel at the input
   always_comb begin
      col_plus1    = CMP_W'(col_ff) + CMP_W'(1);
      row_plus1    = (ROW_W + 1)'(row_ff) + (ROW_W + 1)'(1);
      pos.row_ge1  = (row_ff != '0);
      pos.col_ge1  = (col_ff != '0);
      pos.last_col = (col_plus1 >= width_eff);
      pos.last_row = (row_plus1 >= height_eff);
      pos.interior = (row_ff >= ROW_W'(2)) && (row_plus1 <= height_eff) &&
                     (col_ff >= COL_W'(2)) && (col_plus1 <= width_eff);
   end

   // queue room: an item in stage 1 and the new one may push three each
   assign q_need     = s1_valid_ff ? (QCNT_W + 1)'(2 * MAX_RESULTS)
                                   : (QCNT_W + 1)'(MAX_RESULTS);
   assign req_tready = ((QCNT_W + 1)'(q_count) + q_need) <= (QCNT_W + 1)'(QUEUE_DEPTH);
   assign accept     = req_tvalid && req_tready;

   // raster counters
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         if (pos.last_col) begin
            col_ff <= '0;
            row_ff <= pos.last_row ? '0 : row_plus1[ROW_W-1:0];
         end else begin
            col_ff <= col_plus1[COL_W-1:0];
         end
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req_tdata[PIX_W-1:0];
         s1_col_ff   <= col_ff;
         s1_row_ff   <= row_ff;
         s1_pos_ff   <= pos;
         // stage 1 writes the column being read: forward its data
         byp_ff      <= s1_valid_ff && (s1_col_ff == col_ff);
         byp_data_ff <= {up1, s1_pixel_ff};
      end
   end

   // line stores: upper byte row r-2, lower byte row r-1
   mf3_ram #(
      .WIDTH (2 * PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data ({up1, s1_pixel_ff}),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (line_rd)
   );

   assign line_now = byp_ff ? byp_data_ff : line_rd;
   assign up2      = line_now[2*PIX_W-1:PIX_W];
   assign up1      = line_now[PIX_W-1:0];

   // window of the two previous columns, older/prior/current row each
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_valid_ff) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= up2;
         win_ff[4] <= up1;
         win_ff[5] <= s1_pixel_ff;
      end
   end

   assign nbhd = {s1_pixel_ff, up1, up2,
                  win_ff[5], win_ff[4], win_ff[3],
                  win_ff[2], win_ff[1], win_ff[0]};

   mf3_median u_median (
      .win    (nbhd),
      .median (median)
   );

   // the up to three results of this pixel, in order
   always_comb begin
      res_v[0]            = s1_valid_ff && s1_pos_ff.row_ge1 && s1_pos_ff.col_ge1;
      res[0].pixel        = s1_pos_ff.interior ? median : win_ff[4];
      res[0].row          = s1_row_ff - ROW_W'(1);
      res[0].col          = OUT_COL_W'(s1_col_ff - COL_W'(1));
      res[0].last_frame   = 1'b0;

      res_v[1]            = s1_valid_ff && s1_pos_ff.row_ge1 && s1_pos_ff.last_col;
      res[1].pixel        = up1;
      res[1].row          = s1_row_ff - ROW_W'(1);
      res[1].col          = OUT_COL_W'(s1_col_ff);
      res[1].last_frame   = 1'b0;

      res_v[2]            = s1_valid_ff && s1_pos_ff.last_row;
      res[2].pixel        = s1_pixel_ff;
      res[2].row          = s1_row_ff;
      res[2].col          = OUT_COL_W'(s1_col_ff);
      res[2].last_frame   = s1_pos_ff.last_col;

      res[2].last_item    = 1'b1;
      res[1].last_item    = !res_v[2];
      res[0].last_item    = !res_v[1] && !res_v[2];
   end

   // pack valid results into the low slots
   always_comb begin
      push_cnt = PUSH_CNT_W'(res_v[0]) + PUSH_CNT_W'(res_v[1]) + PUSH_CNT_W'(res_v[2]);
      push_items[2] = res[2];
      push_items[1] = (res_v[0] && res_v[1]) ? res[1] : res[2];
      if (res_v[0]) begin
         push_items[0] = res[0];
      end else if (res_v[1]) begin
         push_items[0] = res[1];
      end else begin
         push_items[0] = res[2];
      end
   end

   mf3_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_cnt   (push_cnt),
      .push_items (push_items),
      .pop        (rsp_tready),
      .out_valid  (rsp_tvalid),
      .out_item   (q_item),
      .count      (q_count)
   );

   assign rsp_tdata = RSP_TDATA_W'({q_item.col, q_item.row, q_item.pixel});
   assign rsp_tuser = q_item.last_item;
   assign rsp_tlast = q_item.last_frame;

endmodule

// ===== hw/rtl/mf3_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read port.
// A read of the address being written returns the old contents.
module mf3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/mf3_median.sv =====
`timescale 1ns / 1ps

// Exact median of a 3x3 window: sort each column, then take the median of
// (largest low, median of mids, smallest high).
module mf3_median (
   input  mf3_pkg::window_type win,
   output mf3_pkg::pixel_type  median
);
   import mf3_pkg::*;

   pixel_type lo  [3];
   pixel_type mid [3];
   pixel_type hi  [3];

   // per-column sort
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         lo[j]  = min3(win[3*j], win[3*j+1], win[3*j+2]);
         mid[j] = med3(win[3*j], win[3*j+1], win[3*j+2]);
         hi[j]  = max3(win[3*j], win[3*j+1], win[3*j+2]);
      end
   end

   assign median = med3(max3(lo[0], lo[1], lo[2]),
                        med3(mid[0], mid[1], mid[2]),
                        min3(hi[0], hi[1], hi[2]));

endmodule

// ===== hw/rtl/mf3_queue.sv =====
`timescale 1ns / 1ps

// Result queue: takes up to three results in one cycle, hands out one.
module mf3_queue (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [mf3_pkg::PUSH_CNT_W-1:0]      push_cnt,
   input  mf3_pkg::rsp_group_type              push_items,
   input  logic                                pop,
   output logic                                out_valid,
   output mf3_pkg::rsp_item_type               out_item,
   output logic [mf3_pkg::QCNT_W-1:0]          count
);
   import mf3_pkg::*;

   rsp_item_type        mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                pop_ok;

   assign pop_ok = pop && (count_ff != '0);

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push_cnt);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(pop_ok);
      count_in  = count_ff + QCNT_W'(push_cnt) - QCNT_W'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entries in slot order
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (PUSH_CNT_W'(i) < push_cnt) begin
            mem_ff[wr_ptr_ff + QPTR_W'(i)] <= push_items[i];
         end
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

// ===== hw/rtl/mf3_checker.sv =====
`timescale 1ns / 1ps
`include "median_filter_3x3_stream_defines.svh"

// Port-level checks for the median filter.
module mf3_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tready,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [mf3_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   input logic                                 rsp_tuser,
   input logic                                 rsp_tlast
);

   // reset empties the queue and leaves room for a pixel
   `MF3_ASSERT_POST_RST(a_rst_empty, clock, reset, !rsp_tvalid)
   `MF3_ASSERT_POST_RST(a_rst_ready, clock, reset, req_tready)

   // the bottom-right pixel is always the last result of its input
   `MF3_ASSERT_IMP(a_frame_end_item_end, clock, reset, rsp_tvalid && rsp_tlast, rsp_tuser)

   // a stalled result holds
   `MF3_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

endmodule

bind median_filter_3x3_stream mf3_checker u_mf3_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== bench/median_filter_3x3_stream_checker.sv =====
`timescale 1ns / 1ps

// Watches both streams and the register port, predicts the filtered pixels
// of every accepted input pixel and compares them with the results in order.
module median_filter_3x3_stream_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   // req_tdata: [7:0] pixel_in
   input  logic [mf3_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // rsp_tdata: [7:0] pixel_out, [23:8] out_row, [34:24] out_col, rest zero
   input  logic [mf3_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // rsp_tuser: [0] last_of_item
   input  logic                              rsp_tuser,
   input  logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [mf3_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [mf3_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output int                                expected_count,
   output int                                mismatch_count
);
   import mf3_pkg::*;

   // predictor copy of the line stores, column window, position and registers
   bit [PIX_W-1:0]          older_line [MAX_WIDTH];
   bit [PIX_W-1:0]          prior_line [MAX_WIDTH];
   bit [PIX_W-1:0]          window [6];
   bit [ROW_W-1:0]          row_pos;
   bit [OUT_COL_W-1:0]      col_pos;
   bit [FRAME_WIDTH_W-1:0]  width_reg;
   bit [FRAME_HEIGHT_W-1:0] height_reg;

   // filtered pixels still owed by the block, oldest first
   rsp_item_type expected_pixels [$];

   function automatic rsp_item_type result_item(input pixel_type px, input int unsigned r,
                                                input int unsigned c, input bit frame_end);
      rsp_item_type item;
      item.pixel      = px;
      item.row        = ROW_W'(r);
      item.col        = OUT_COL_W'(c);
      item.last_item  = 1'b0;
      item.last_frame = frame_end;
      return item;
   endfunction

   // one input pixel: queue the pixels it completes, then advance the state
   task automatic filter_pixel(input pixel_type px);
      int unsigned  w, h, r, c, ci;
      int           i, j;
      bit           last_col, last_row;
      pixel_type    up2, up1, v, key;
      pixel_type    hood [9];
      rsp_item_type produced [$];
      w = width_reg;
      h = height_reg;
      if (w == 0) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      if (h == 0) h = 1;
      r = row_pos;
      c = col_pos;
      last_col = (c + 1 >= w);
      last_row = (r + 1 >= h);
      ci = c % MAX_WIDTH;
      up2 = older_line[ci];
      up1 = prior_line[ci];

      // pixel one row up and one column left
      if (r >= 1 && c >= 1) begin
         if (r >= 2 && r + 1 <= h && c >= 2 && c + 1 <= w) begin
            hood[0] = window[0]; hood[1] = window[3]; hood[2] = up2;
            hood[3] = window[1]; hood[4] = window[4]; hood[5] = up1;
            hood[6] = window[2]; hood[7] = window[5]; hood[8] = px;
            for (i = 1; i < 9; i++) begin
               key = hood[i];
               j = i;
               while (j > 0 && hood[j-1] > key) begin
                  hood[j] = hood[j-1];
                  j--;
               end
               hood[j] = key;
            end
            v = hood[4];
         end else begin
            v = window[4];
         end
         produced.push_back(result_item(v, r - 1, c - 1, 1'b0));
      end
      // right border of the row above
      if (r >= 1 && last_col)
         produced.push_back(result_item(up1, r - 1, c, 1'b0));
      // bottom row goes straight through
      if (last_row)
         produced.push_back(result_item(px, r, c, last_col));
      if (produced.size() > 0)
         produced[produced.size()-1].last_item = 1'b1;
      foreach (produced[k])
         expected_pixels.push_back(produced[k]);

      older_line[ci] = up1;
      prior_line[ci] = px;
      window[0] = window[3];
      window[1] = window[4];
      window[2] = window[5];
      window[3] = up2;
      window[4] = up1;
      window[5] = px;
      if (last_col) begin
         col_pos = '0;
         row_pos = last_row ? '0 : ROW_W'(r + 1);
      end else begin
         col_pos = OUT_COL_W'(c + 1);
      end
   endtask

   task automatic report(input string what);
      mismatch_count++;
      $display("%0t ns: %s", $time, what);
   endtask

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got, input rsp_item_type want_item);
      if (want != got)
         report($sformatf("%s at row %0d col %0d: expected %0d, actual %0d",
                          name, want_item.row, want_item.col, want, got));
   endtask

   // one result transfer against the oldest expectation
   task automatic check_result();
      rsp_item_type want, got;
      got.pixel      = rsp_tdata[PIX_W-1:0];
      got.row        = rsp_tdata[PIX_W +: ROW_W];
      got.col        = rsp_tdata[PIX_W+ROW_W +: OUT_COL_W];
      got.last_item  = rsp_tuser;
      got.last_frame = rsp_tlast;
      if (expected_pixels.size() == 0) begin
         report($sformatf("result transfer: expected none, actual pixel %0d row %0d col %0d",
                          got.pixel, got.row, got.col));
      end else begin
         want = expected_pixels.pop_front();
         compare_field("pixel_out", want.pixel, got.pixel, want);
         compare_field("out_row", want.row, got.row, want);
         compare_field("out_col", want.col, got.col, want);
         compare_field("last_of_item", want.last_item, got.last_item, want);
         compare_field("last_of_frame", want.last_frame, got.last_frame, want);
      end
   endtask

   initial begin
      mismatch_count = 0;
      expected_count = 0;
   end

   // sample every transfer at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         foreach (window[k]) window[k] = '0;
         row_pos    = '0;
         col_pos    = '0;
         width_reg  = FRAME_WIDTH_RST;
         height_reg = FRAME_HEIGHT_RST;
         expected_pixels.delete();
      end else begin
         if (csr_we) begin
            if (csr_addr == CSR_FRAME_WIDTH)
               width_reg = csr_wdata[FRAME_WIDTH_W-1:0];
            else if (csr_addr == CSR_FRAME_HEIGHT)
               height_reg = csr_wdata[FRAME_HEIGHT_W-1:0];
         end
         if (req_tvalid && req_tready)
            filter_pixel(req_tdata[PIX_W-1:0]);
         if (rsp_tvalid && rsp_tready)
            check_result();
      end
      expected_count = expected_pixels.size();
   end

endmodule

// ===== bench/median_filter_3x3_stream_tb.sv =====
`timescale 1ns / 1ps

module median_filter_3x3_stream_tb;
   import mf3_pkg::*;

   localparam int QUIET_LIMIT   = 2000;
   localparam int LONG_HOLD     = 300;
   localparam int RANDOM_ITEMS  = 360;
   localparam int SETTLE_CYCLES = 8;

   typedef enum int {
      PAT_RANDOM,
      PAT_ZERO,
      PAT_FULL,
      PAT_FEW,
      PAT_CHECKER
   } pixel_pattern_type;

   typedef enum int {
      READY_ALWAYS,
      READY_RANDOM,
      READY_SPARSE,
      READY_MOSTLY
   } ready_style_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic                    rsp_tuser;
   logic                    rsp_tlast;
   logic                    csr_we;
   logic [CSR_ADDR_W-1:0]   csr_addr;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   int expected_count;
   int mismatch_count;
   int quiet_cycles = 0;
   int burst_left = 0;
   int hold_requests = 0;
   int hold_served = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   median_filter_3x3_stream DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   median_filter_3x3_stream_checker filter_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .expected_count (expected_count),
      .mismatch_count (mismatch_count)
   );

   // watchdog: a stretch without a transfer on any port that reaches QUIET_LIMIT is a hang
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // receiver: switches among random stall styles, long hold on request
   initial begin : rsp_side
      int unsigned     tick;
      ready_style_type style;
      tick = 0;
      style = READY_ALWAYS;
      rsp_tready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end
         if (tick % 50 == 0)
            style = ready_style_type'($urandom_range(0, 3));
         tick++;
         case (style)
            READY_ALWAYS: rsp_tready <= 1'b1;
            READY_RANDOM: rsp_tready <= 1'($urandom_range(0, 1));
            READY_SPARSE: rsp_tready <= (tick % 4 == 0);
            default:      rsp_tready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   function automatic pixel_type pick_pixel(input pixel_pattern_type pat,
                                            input int unsigned k);
      case (pat)
         PAT_ZERO:    return 8'd0;
         PAT_FULL:    return 8'd255;
         PAT_CHECKER: return k[0] ? 8'd255 : 8'd0;
         PAT_FEW: begin
            case ($urandom_range(0, 4))
               0:       return 8'd0;
               1:       return 8'd1;
               2:       return 8'd128;
               3:       return 8'd254;
               default: return 8'd255;
            endcase
         end
         default:     return pixel_type'($urandom_range(0, 255));
      endcase
   endfunction

   // one pixel transfer; bursts of random length with random gaps after them
   task automatic push_pixel(input pixel_type px);
      int unsigned gap;
      req_tdata  <= px;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            req_tdata  <= REQ_TDATA_W'($urandom);
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   task automatic send_frame(input int unsigned count, input pixel_pattern_type pat);
      for (int unsigned k = 0; k < count; k++)
         push_pixel(pick_pixel(pat, k));
      req_tvalid <= 1'b0;
   endtask

   // wait for every owed result, then let the pipeline settle
   task automatic drain();
      while (expected_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // register writes only with the block idle
   task automatic configure(input logic [CSR_DATA_W-1:0] width_val,
                            input logic [CSR_DATA_W-1:0] height_val);
      drain();
      csr_we    <= 1'b1;
      csr_addr  <= CSR_FRAME_WIDTH;
      csr_wdata <= width_val;
      @(negedge clock);
      csr_addr  <= CSR_FRAME_HEIGHT;
      csr_wdata <= height_val;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin : stimulus
      int unsigned       w, h, w_eff, h_eff, random_items, frame_idx;
      pixel_pattern_type pat;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_addr   <= CSR_FRAME_WIDTH;
      csr_wdata  <= '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // zero width and height both act as one: single-pixel frame
      configure(16'd0, 16'd0);
      send_frame(1, PAT_FULL);
      // frames below 3x3 pass through whole
      configure(16'd2, 16'd2);
      send_frame(4, PAT_CHECKER);
      // smallest frame with an interior pixel, heavy on ties and extremes
      configure(16'd3, 16'd3);
      send_frame(9, PAT_FEW);
      // one column, tallest height (upper write bits dropped), cut short by
      // dropping the height mid-frame so the next pixel closes it
      configure(16'hF001, 16'hFFFF);
      send_frame(6, PAT_RANDOM);
      configure(16'd1, 16'd0);
      send_frame(1, PAT_RANDOM);

      // random frame sizes and contents
      random_items = 0;
      frame_idx = 0;
      while (random_items < RANDOM_ITEMS) begin
         w = $urandom_range(0, 12);
         h = $urandom_range(0, 7);
         if (frame_idx == 3) begin
            w = 10;
            h = 6;
         end
         w_eff = (w == 0) ? 1 : w;
         h_eff = (h == 0) ? 1 : h;
         pat = pixel_pattern_type'($urandom_range(0, 4));
         if ($urandom_range(0, 1) == 1)
            pat = PAT_RANDOM;
         configure(16'(w), 16'(h));
         // long receiver stall while pixels keep coming: queue fills up
         if (frame_idx == 3)
            hold_requests++;
         send_frame(w_eff * h_eff, pat);
         random_items += w_eff * h_eff;
         frame_idx++;
      end

      // width above the line store size acts as the full store width; the
      // row is closed early by dropping the width mid-frame
      configure(16'd4095, 16'd1);
      send_frame(16, PAT_RANDOM);
      configure(16'd1, 16'd1);
      send_frame(1, PAT_RANDOM);

      drain();
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
